FILE: rtl/kvta_pkg.sv
// Shared types and constants of the key/value text address extractor.
// Holds the parse phase enum, the result record and the sizing constants.
// No dependencies; used by kvta_parser and the top level.
package kvta_pkg;

    // sizing
    localparam int MAX_ENTRIES     = 16;
    localparam int ADDR_BYTES      = 64;
    localparam int MAX_NESTING     = 3;
    localparam int SKIP_DEPTH_BITS = 16;

    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int LEN_W  = $clog2(ADDR_BYTES);
    localparam int NEST_W = $clog2(MAX_NESTING + 1);

    // characters
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // key match progress codes
    localparam logic [2:0] MATCH_DONE = 3'd4;
    localparam logic [2:0] MATCH_FAIL = 3'd5;

    typedef enum logic [3:0] {
        PH_ROOT_WS    = 4'd0,
        PH_ROOT_KEY   = 4'd1,
        PH_ROOT_AFTER = 4'd2,
        PH_ENTRY_WS   = 4'd3,
        PH_KEY        = 4'd4,
        PH_AFTER_KEY  = 4'd5,
        PH_VALUE      = 4'd6,
        PH_SKIP       = 4'd7,
        PH_HALT       = 4'd8
    } phase_t;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] addr_byte;
        logic       last_of_entry;
        logic [3:0] entry_index;
        logic       finished;
        logic [4:0] entries_found;
        logic       success;
    } result_t;

    // key character expected at a given match position
    function automatic logic [7:0] addr_char(input logic [1:0] pos);
        logic [7:0] ch;
        case (pos)
            2'd0:    ch = 8'h61;
            2'd1:    ch = 8'h64;
            2'd2:    ch = 8'h64;
            default: ch = 8'h72;
        endcase
        return ch;
    endfunction

endpackage

FILE: rtl/kvta_parser.sv
// Parser state machine of the key/value text address extractor.
// Updates its state on each accepted byte and forms the result of that byte.
// Depends on kvta_pkg.
module kvta_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          text_byte,
    input  logic                end_of_text,
    output logic                res_valid,
    output kvta_pkg::result_t   res
);

    localparam logic [kvta_pkg::SKIP_DEPTH_BITS-1:0] SKIP_MAX = '1;
    localparam logic [kvta_pkg::CNT_W-1:0] CNT_LIMIT =
        kvta_pkg::CNT_W'(kvta_pkg::MAX_ENTRIES);
    localparam logic [kvta_pkg::LEN_W-1:0] LEN_LIMIT =
        kvta_pkg::LEN_W'(kvta_pkg::ADDR_BYTES - 1);
    localparam logic [kvta_pkg::NEST_W-1:0] NEST_LIMIT =
        kvta_pkg::NEST_W'(kvta_pkg::MAX_NESTING);

    kvta_pkg::phase_t                    phase_reg, phase_next;
    logic [kvta_pkg::NEST_W-1:0]         nest_reg, nest_next;
    logic [kvta_pkg::SKIP_DEPTH_BITS-1:0] skip_reg, skip_next;
    logic [2:0]                          match_reg, match_next;
    logic                                is_addr_reg, is_addr_next;
    logic [kvta_pkg::LEN_W-1:0]          len_reg, len_next;
    logic [7:0]                          held_reg, held_next;
    logic                                held_valid_reg, held_valid_next;
    logic [kvta_pkg::CNT_W-1:0]          count_reg, count_next;

    logic                                eot;
    logic                                is_space;
    logic [7:0]                          low_ch;
    kvta_pkg::phase_t                    ent_phase;
    logic [kvta_pkg::NEST_W-1:0]         ent_nest;
    logic [kvta_pkg::CNT_W-1:0]          count_inc;

    assign eot = end_of_text || (text_byte == kvta_pkg::CH_NUL);
    assign is_space = (text_byte == kvta_pkg::CH_SPACE) || (text_byte == kvta_pkg::CH_TAB)
                   || (text_byte == kvta_pkg::CH_CR) || (text_byte == kvta_pkg::CH_LF);
    assign low_ch = (text_byte >= 8'h41 && text_byte <= 8'h5A) ? (text_byte | 8'h20)
                                                                : text_byte;
    assign count_inc = count_reg + 1'b1;

    // byte where a key or a closing brace is expected
    always_comb
    begin
        ent_phase = phase_reg;
        ent_nest  = nest_reg;
        if (is_space)
        begin
            ent_phase = kvta_pkg::PH_ENTRY_WS;
        end
        else if (text_byte == kvta_pkg::CH_QUOTE)
        begin
            ent_phase = kvta_pkg::PH_KEY;
        end
        else if (text_byte == kvta_pkg::CH_RBRACE && nest_reg != '0)
        begin
            ent_phase = kvta_pkg::PH_ENTRY_WS;
            ent_nest  = nest_reg - 1'b1;
        end
        else
        begin
            ent_phase = kvta_pkg::PH_HALT;
        end
    end

    // next state and result
    always_comb
    begin
        phase_next      = phase_reg;
        nest_next       = nest_reg;
        skip_next       = skip_reg;
        match_next      = match_reg;
        is_addr_next    = is_addr_reg;
        len_next        = len_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        count_next      = count_reg;
        res_valid       = 1'b0;
        res             = '0;

        if (eot)
        begin
            res_valid = 1'b1;
            res.finished = 1'b1;
            if (phase_reg == kvta_pkg::PH_VALUE && is_addr_reg && held_valid_reg)
            begin
                res.byte_valid    = 1'b1;
                res.addr_byte     = held_reg;
                res.last_of_entry = 1'b1;
                res.entry_index   = count_reg[3:0];
                res.entries_found = 5'(count_inc);
                res.success       = 1'b1;
            end
            else
            begin
                res.entries_found = 5'(count_reg);
                res.success       = (count_reg != '0);
            end
            phase_next      = kvta_pkg::PH_ROOT_WS;
            nest_next       = '0;
            skip_next       = '0;
            match_next      = '0;
            is_addr_next    = 1'b0;
            len_next        = '0;
            held_next       = '0;
            held_valid_next = 1'b0;
            count_next      = '0;
        end
        else
        begin
            case (phase_reg)
                kvta_pkg::PH_ROOT_WS:
                begin
                    if (text_byte == kvta_pkg::CH_QUOTE)
                        phase_next = kvta_pkg::PH_ROOT_KEY;
                    else if (!is_space)
                        phase_next = kvta_pkg::PH_HALT;
                end
                kvta_pkg::PH_ROOT_KEY:
                begin
                    if (text_byte == kvta_pkg::CH_QUOTE)
                        phase_next = kvta_pkg::PH_ROOT_AFTER;
                end
                kvta_pkg::PH_ROOT_AFTER:
                begin
                    if (text_byte == kvta_pkg::CH_LBRACE)
                    begin
                        nest_next  = '0;
                        phase_next = kvta_pkg::PH_ENTRY_WS;
                    end
                    else if (!is_space)
                    begin
                        phase_next = kvta_pkg::PH_HALT;
                    end
                end
                kvta_pkg::PH_ENTRY_WS:
                begin
                    phase_next = ent_phase;
                    nest_next  = ent_nest;
                    if (text_byte == kvta_pkg::CH_QUOTE)
                        match_next = '0;
                end
                kvta_pkg::PH_KEY:
                begin
                    if (text_byte == kvta_pkg::CH_QUOTE)
                    begin
                        is_addr_next = (match_reg == kvta_pkg::MATCH_DONE);
                        phase_next   = kvta_pkg::PH_AFTER_KEY;
                    end
                    else if (match_reg < kvta_pkg::MATCH_DONE)
                    begin
                        if (low_ch == kvta_pkg::addr_char(match_reg[1:0]))
                            match_next = match_reg + 1'b1;
                        else
                            match_next = kvta_pkg::MATCH_FAIL;
                    end
                    else
                    begin
                        match_next = kvta_pkg::MATCH_FAIL;
                    end
                end
                kvta_pkg::PH_AFTER_KEY:
                begin
                    if (is_space)
                    begin
                        phase_next = phase_reg;
                    end
                    else if (text_byte == kvta_pkg::CH_LBRACE)
                    begin
                        if (nest_reg < NEST_LIMIT)
                        begin
                            nest_next  = nest_reg + 1'b1;
                            phase_next = kvta_pkg::PH_ENTRY_WS;
                        end
                        else
                        begin
                            skip_next  = kvta_pkg::SKIP_DEPTH_BITS'(1);
                            phase_next = kvta_pkg::PH_SKIP;
                        end
                    end
                    else if (text_byte == kvta_pkg::CH_QUOTE)
                    begin
                        is_addr_next    = is_addr_reg && (count_reg < CNT_LIMIT);
                        len_next        = '0;
                        held_valid_next = 1'b0;
                        held_next       = '0;
                        phase_next      = kvta_pkg::PH_VALUE;
                    end
                    else
                    begin
                        phase_next = ent_phase;
                        nest_next  = ent_nest;
                    end
                end
                kvta_pkg::PH_VALUE:
                begin
                    if (text_byte == kvta_pkg::CH_QUOTE)
                    begin
                        phase_next   = kvta_pkg::PH_ENTRY_WS;
                        is_addr_next = 1'b0;
                        if (is_addr_reg && held_valid_reg)
                        begin
                            count_next        = count_inc;
                            res_valid         = 1'b1;
                            res.byte_valid    = 1'b1;
                            res.addr_byte     = held_reg;
                            res.last_of_entry = 1'b1;
                            res.entry_index   = count_reg[3:0];
                            res.entries_found = 5'(count_inc);
                            held_valid_next   = 1'b0;
                            held_next         = '0;
                        end
                    end
                    else if (is_addr_reg && len_reg < LEN_LIMIT)
                    begin
                        held_next       = text_byte;
                        held_valid_next = 1'b1;
                        len_next        = len_reg + 1'b1;
                        if (held_valid_reg)
                        begin
                            res_valid         = 1'b1;
                            res.byte_valid    = 1'b1;
                            res.addr_byte     = held_reg;
                            res.entry_index   = count_reg[3:0];
                            res.entries_found = 5'(count_reg);
                        end
                    end
                end
                kvta_pkg::PH_SKIP:
                begin
                    if (text_byte == kvta_pkg::CH_LBRACE)
                    begin
                        if (skip_reg < SKIP_MAX)
                            skip_next = skip_reg + 1'b1;
                    end
                    else if (text_byte == kvta_pkg::CH_RBRACE)
                    begin
                        if (skip_reg <= kvta_pkg::SKIP_DEPTH_BITS'(1))
                        begin
                            skip_next  = '0;
                            phase_next = kvta_pkg::PH_ENTRY_WS;
                        end
                        else
                        begin
                            skip_next = skip_reg - 1'b1;
                        end
                    end
                end
                default:
                begin
                    phase_next = kvta_pkg::PH_HALT;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= kvta_pkg::PH_ROOT_WS;
            nest_reg       <= '0;
            skip_reg       <= '0;
            match_reg      <= '0;
            is_addr_reg    <= 1'b0;
            len_reg        <= '0;
            held_reg       <= '0;
            held_valid_reg <= 1'b0;
            count_reg      <= '0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            nest_reg       <= nest_next;
            skip_reg       <= skip_next;
            match_reg      <= match_next;
            is_addr_reg    <= is_addr_next;
            len_reg        <= len_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            count_reg      <= count_next;
        end
    end

`ifndef SYNTHESIS
    // entry count never passes the limit
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_LIMIT)
        else $error("entry count beyond limit");

    // a held byte only exists inside a value
    a_held_in_value: assert property (@(posedge clk) disable iff (!rst_n)
        held_valid_reg |-> (phase_reg == kvta_pkg::PH_VALUE))
        else $error("held byte outside a value");

    // nesting level stays within the tracked depth
    a_nest_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nest_reg <= NEST_LIMIT)
        else $error("nesting level beyond limit");
`endif

endmodule

FILE: rtl/keyvalue_text_address_extractor_unit.sv
// Top level of the key/value text address extractor.
// Handles the request handshakes and a two-entry result stage; depends on
// kvta_pkg and kvta_parser.
//
// Takes one text byte per cycle, back to back, and gives at most one result
// per byte: a value character of an addr entry (delayed by one byte so the
// last one can be marked) or the finished record at end of text. The parser
// state updates in the cycle the request is accepted; its result lands in a
// two-entry output stage, so input keeps flowing while one result waits, and
// input stalls only when both entries are full.
module keyvalue_text_address_extractor_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] text_byte,
    input  logic       end_of_text,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       byte_valid,
    output logic [7:0] addr_byte,
    output logic       last_of_entry,
    output logic [3:0] entry_index,
    output logic       finished,
    output logic [4:0] entries_found,
    output logic       success
);

    logic              accept;
    logic              take;
    logic              res_valid;
    kvta_pkg::result_t res;

    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    kvta_pkg::result_t out_data_reg, out_data_next;
    kvta_pkg::result_t skid_data_reg, skid_data_next;

    assign in_ready = !skid_valid_reg;
    assign accept   = in_valid && in_ready;
    assign take     = out_valid_reg && out_ready;

    // parser
    kvta_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (accept),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .res_valid   (res_valid),
        .res         (res)
    );

    // two-entry result stage
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (take)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        if (accept && res_valid)
        begin
            if (!out_valid_reg || take)
            begin
                out_data_next  = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_data_next  = res;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // outputs
    assign out_valid     = out_valid_reg;
    assign byte_valid    = out_data_reg.byte_valid;
    assign addr_byte     = out_data_reg.addr_byte;
    assign last_of_entry = out_data_reg.last_of_entry;
    assign entry_index   = out_data_reg.entry_index;
    assign finished      = out_data_reg.finished;
    assign entries_found = out_data_reg.entries_found;
    assign success       = out_data_reg.success;

`ifndef SYNTHESIS
    // the spare entry fills only behind a waiting result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry full with output empty");

    // a stalled result moves on to the output when taken
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_ready) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid entry not drained");

    // success reported only with a finish and a nonzero count
    a_success_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && success) |-> (finished && entries_found != 5'd0))
        else $error("success without finish or entries");
`endif

endmodule
